### rtl/rrp_pkg.sv
// ---------------------------------------------------------------------------
// rrp_pkg: shared types and constants of the RISC-V relocation patcher
// Command and status codes, instruction field masks and transaction structs.
// ---------------------------------------------------------------------------
package rrp_pkg;

   // command codes
   localparam logic [3:0] CMD_ABS64   = 4'd0;
   localparam logic [3:0] CMD_PCREL32 = 4'd1;
   localparam logic [3:0] CMD_CALL    = 4'd2;
   localparam logic [3:0] CMD_HI20    = 4'd3;
   localparam logic [3:0] CMD_LO12_I  = 4'd4;
   localparam logic [3:0] CMD_LO12_S  = 4'd5;
   localparam logic [3:0] CMD_ADD8    = 4'd6;
   localparam logic [3:0] CMD_SET8    = 4'd7;
   localparam logic [3:0] CMD_ADD32   = 4'd8;
   localparam logic [3:0] CMD_SKIP    = 4'd9;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_SKIPPED     = 3'd1,
      ST_MISALIGNED  = 3'd2,
      ST_BAD_INSN    = 3'd3,
      ST_OVERFLOW    = 3'd4,
      ST_MISSING     = 3'd5,
      ST_UNSUPPORTED = 3'd6
   } rrp_status_type;

   // opcodes and field masks
   localparam logic [31:0] OPC_MASK        = 32'h0000_007F;
   localparam logic [31:0] OPC_AUIPC       = 32'h0000_0017;
   localparam logic [31:0] OPC_JALR        = 32'h0000_0067;
   localparam logic [31:0] OPC_OPIMM       = 32'h0000_0013;
   localparam logic [31:0] OPC_LOAD        = 32'h0000_0003;
   localparam logic [31:0] OPC_STORE       = 32'h0000_0023;
   localparam logic [31:0] JALR_CHECK_MASK = 32'h0000_707F;
   localparam logic [31:0] KEEP_U          = 32'h0000_0FFF;
   localparam logic [31:0] KEEP_I          = 32'h000F_FFFF;
   localparam logic [31:0] KEEP_S          = 32'h01FF_F07F;

   // exact sums carry two extra bits over the 64-bit address range
   localparam int unsigned SUM_W = 66;
   localparam logic [SUM_W-1:0] HI_ROUND = 66'h800;

   typedef struct packed {
      logic [3:0]         command;
      logic [31:0]        first_word;
      logic [31:0]        second_word;
      logic [63:0]        symbol_address;
      logic signed [63:0] addend;
      logic [63:0]        place_address;
      logic [1:0]         offset_low_bits;
      logic [63:0]        sub_symbol_address;
      logic signed [63:0] sub_addend;
      logic               pair_present;
      logic signed [63:0] paired_delta;
   } rrp_req_type;

   typedef struct packed {
      logic [63:0]    patch_value;
      logic [3:0]     patch_bytes;
      logic [31:0]    patched_second;
      logic           write_second;
      logic           needs_rebase;
      rrp_status_type status;
   } rrp_rsp_type;

   // what the input register holds for the patch logic
   typedef struct packed {
      logic [3:0]       command;
      logic [31:0]      first_word;
      logic [31:0]      second_word;
      logic [63:0]      place_address;
      logic [1:0]       offset_low_bits;
      logic             pair_present;
      logic [11:0]      paired_low;
      logic [SUM_W-1:0] target_sum;
      logic [SUM_W-1:0] target_round;
      logic [31:0]      diff_sum;
   } rrp_stage_type;

endpackage

### rtl/rrp_ifs.sv
// ---------------------------------------------------------------------------
// rrp_ifs: valid/ready channels of the relocation patcher
// One interface for relocation requests, one for patch results.
// ---------------------------------------------------------------------------
interface rrp_req_if import rrp_pkg::*; ();
   logic        valid;
   logic        ready;
   rrp_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rrp_rsp_if import rrp_pkg::*; ();
   logic        valid;
   logic        ready;
   rrp_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/rrp_front.sv
// ---------------------------------------------------------------------------
// rrp_front: input register of the relocation patcher
// Forms the exact target sums on the way in and holds one transaction.
// ---------------------------------------------------------------------------
module rrp_front import rrp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rrp_req_if.sink       req_chan,
   input  logic          take,
   output logic          stage_valid,
   output rrp_stage_type stage_data
);

   logic          valid_ff, valid_in;
   rrp_stage_type data_ff, data_in;
   logic          load;
   logic [SUM_W-1:0] sym_ext, add_ext;

   assign req_chan.ready = !valid_ff || take;
   assign load = req_chan.valid && req_chan.ready;

   always_comb begin
      sym_ext = {2'b00, req_chan.payload.symbol_address};
      add_ext = {{2{req_chan.payload.addend[63]}}, req_chan.payload.addend};

      data_in.command         = req_chan.payload.command;
      data_in.first_word      = req_chan.payload.first_word;
      data_in.second_word     = req_chan.payload.second_word;
      data_in.place_address   = req_chan.payload.place_address;
      data_in.offset_low_bits = req_chan.payload.offset_low_bits;
      data_in.pair_present    = req_chan.payload.pair_present;
      data_in.paired_low      = req_chan.payload.paired_delta[11:0];
      // S + A and S + A + 0x800 side by side so the patch logic only subtracts P
      data_in.target_sum      = sym_ext + add_ext;
      data_in.target_round    = sym_ext + add_ext + HI_ROUND;
      // symbol differences are taken modulo 2^32 at most
      data_in.diff_sum        = req_chan.payload.symbol_address[31:0]
                              + req_chan.payload.addend[31:0]
                              - req_chan.payload.sub_symbol_address[31:0]
                              - req_chan.payload.sub_addend[31:0];

      valid_in = load || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

### rtl/rrp_patch.sv
// ---------------------------------------------------------------------------
// rrp_patch: relocation decode, checks and instruction splicing
// Turns one registered relocation into the patch result.
// ---------------------------------------------------------------------------
module rrp_patch import rrp_pkg::*; (
   input  rrp_stage_type stage_data,
   output rrp_rsp_type   result
);

   logic [SUM_W-1:0] delta;
   logic [SUM_W-1:0] hi_sum;
   logic             fits32;
   logic             fits20;
   logic [31:0]      w1, w2;
   logic [31:0]      opc;
   logic             auipc_ok;
   logic             jalr_ok;
   logic [31:0]      diff_total;
   logic [11:0]      low;

   always_comb begin
      w1     = stage_data.first_word;
      w2     = stage_data.second_word;
      opc    = w1 & OPC_MASK;
      low    = stage_data.paired_low;
      delta  = stage_data.target_sum - {2'b00, stage_data.place_address};
      hi_sum = stage_data.target_round - {2'b00, stage_data.place_address};
      // signed range: all bits from the sign position up agree
      fits32 = (&delta[SUM_W-1:31]) || !(|delta[SUM_W-1:31]);
      fits20 = (&hi_sum[SUM_W-1:31]) || !(|hi_sum[SUM_W-1:31]);
      auipc_ok = (opc == OPC_AUIPC);
      jalr_ok  = ((w2 & JALR_CHECK_MASK) == OPC_JALR);
      diff_total = ((stage_data.command == CMD_SET8) ? 32'd0 : w1) + stage_data.diff_sum;

      result.patch_value    = '0;
      result.patch_bytes    = 4'd0;
      result.patched_second = '0;
      result.write_second   = 1'b0;
      result.needs_rebase   = 1'b0;
      result.status         = ST_OK;

      case (stage_data.command)
         CMD_SKIP: begin
            result.status = ST_SKIPPED;
         end
         CMD_ABS64: begin
            if (stage_data.target_sum[SUM_W-1:64] != 2'b00) begin
               result.status = ST_OVERFLOW;
            end else begin
               result.patch_value  = stage_data.target_sum[63:0];
               result.patch_bytes  = 4'd8;
               result.needs_rebase = 1'b1;
            end
         end
         CMD_PCREL32: begin
            if (!fits32) begin
               result.status = ST_OVERFLOW;
            end else begin
               result.patch_value = {32'd0, delta[31:0]};
               result.patch_bytes = 4'd4;
            end
         end
         CMD_ADD8, CMD_SET8, CMD_ADD32: begin
            if (!stage_data.pair_present) begin
               result.status = ST_MISSING;
            end else if (stage_data.command == CMD_ADD32) begin
               result.patch_value = {32'd0, diff_total};
               result.patch_bytes = 4'd4;
            end else begin
               result.patch_value = {56'd0, diff_total[7:0]};
               result.patch_bytes = 4'd1;
            end
         end
         CMD_CALL, CMD_HI20: begin
            if (stage_data.offset_low_bits != 2'b00) begin
               result.status = ST_MISALIGNED;
            end else if (!auipc_ok || (stage_data.command == CMD_CALL && !jalr_ok)) begin
               result.status = ST_BAD_INSN;
            end else if (!fits20) begin
               result.status = ST_OVERFLOW;
            end else begin
               result.patch_value = {32'd0, hi_sum[31:12], w1[11:0]};
               result.patch_bytes = 4'd4;
               if (stage_data.command == CMD_CALL) begin
                  result.patched_second = {delta[11:0], w2[19:0]};
                  result.write_second   = 1'b1;
               end
            end
         end
         CMD_LO12_I, CMD_LO12_S: begin
            if (stage_data.offset_low_bits != 2'b00) begin
               result.status = ST_MISALIGNED;
            end else if (!stage_data.pair_present) begin
               result.status = ST_MISSING;
            end else if (stage_data.command == CMD_LO12_I) begin
               if (opc != OPC_OPIMM && opc != OPC_LOAD && opc != OPC_JALR) begin
                  result.status = ST_BAD_INSN;
               end else begin
                  result.patch_value = {32'd0, low, w1[19:0]};
                  result.patch_bytes = 4'd4;
               end
            end else begin
               if (opc != OPC_STORE) begin
                  result.status = ST_BAD_INSN;
               end else begin
                  // S form: imm[11:5] to bits 31:25, imm[4:0] to bits 11:7
                  result.patch_value = {32'd0, low[11:5], w1[24:12], low[4:0], w1[6:0]};
                  result.patch_bytes = 4'd4;
               end
            end
         end
         default: begin
            result.status = ST_UNSUPPORTED;
         end
      endcase
   end

endmodule

### rtl/riscv_relocation_patcher_unit.sv
// Path to the result: two registers, the input register and then the result register.
// Throughput: one transaction per cycle unless rsp_chan stalls; the input register
// takes an item when empty or the result register is free or drained in the same cycle.
// The path between the registers is two 66-bit subtracts, range compares and splicing.
// Reset (synchronous, active high) empties both registers; no other state exists.
// ---------------------------------------------------------------------------
// riscv_relocation_patcher_unit: RISC-V relocation patcher, top level
// Checks one relocation per transaction and returns the patched words or a status.
// ---------------------------------------------------------------------------
module riscv_relocation_patcher_unit import rrp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   rrp_req_if.sink   req_chan,
   rrp_rsp_if.source rsp_chan
);

   logic          stage_valid;
   rrp_stage_type stage_data;
   rrp_rsp_type   result;
   logic          out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   rrp_rsp_type rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   rrp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .take        (out_free),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   rrp_patch u_patch (
      .stage_data (stage_data),
      .result     (result)
   );

   assign rsp_valid_in = (stage_valid && out_free) || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (stage_valid && out_free) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      stage_valid && out_free |=> rsp_valid_ff)
      else $error("staged transaction did not reach the result register");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |->
         rsp_data_ff.patch_value == '0 && rsp_data_ff.patch_bytes == 4'd0 &&
         !rsp_data_ff.write_second && !rsp_data_ff.needs_rebase)
      else $error("failed relocation carries patch data");

   a_second_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.write_second |->
         rsp_data_ff.status == ST_OK && rsp_data_ff.patch_bytes == 4'd4)
      else $error("call pair result without a four-byte first word");

   a_rebase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.needs_rebase |-> rsp_data_ff.patch_bytes == 4'd8)
      else $error("rebase flag on a result that is not a 64-bit pointer");

endmodule
